// ----- rtl/dsat_pkg.sv -----
// shared constants and types for the dsatur colorer
package dsat_pkg;
  localparam int unsigned MaxVertices = 64;
  localparam int unsigned VcntW = 7;
  localparam int unsigned VidW = 6;
  localparam int unsigned DegW = 8;
  localparam int unsigned SatW = 7;
  localparam logic CmdAddEdge = 1'b0;
  localparam logic CmdRun = 1'b1;

  // broadcast from the controller to every vertex cell
  typedef struct packed {
    logic       clear;
    logic       edge_en;
    logic [5:0] edge_a;
    logic [5:0] edge_b;
    logic       color_en;
    logic [5:0] color_v;
    logic [5:0] color_c;
  } dsat_bcast_t;

  // key handed along the chain for the max search
  typedef struct packed {
    logic            valid;
    logic [SatW-1:0] sat;
    logic [DegW-1:0] deg;
    logic [5:0]      idx;
  } dsat_key_t;
endpackage

// ----- rtl/dsat_cell.sv -----
// one vertex cell: adjacency row, degree, seen colors, saturation
module dsat_cell
  import dsat_pkg::*;
#(
  parameter int unsigned NumV = MaxVertices,
  parameter logic [5:0] Idx = 6'd0
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dsat_bcast_t bc_i,
  input  logic        live_i,
  input  dsat_key_t   key_i,
  output dsat_key_t   key_o,
  output logic [63:0] seen_o
);
  logic [NumV-1:0] adj_q, adj_d;
  logic [DegW-1:0] deg_q, deg_d;
  logic [63:0]     seen_q, seen_d;
  logic [SatW-1:0] sat_q, sat_d;
  logic            done_q, done_d;
  dsat_key_t       key_q, key_d;
  logic            cand;
  logic            better;
  logic [1:0]      inc;
  logic [DegW:0]   dsum;

  always_comb begin
    adj_d = adj_q; deg_d = deg_q; seen_d = seen_q; sat_d = sat_q; done_d = done_q;
    inc = 2'd0;
    dsum = '0;
    if (bc_i.clear) begin
      adj_d = '0; deg_d = '0; seen_d = '0; sat_d = '0; done_d = 1'b0;
    end else if (bc_i.edge_en) begin
      if (bc_i.edge_a == Idx) begin
        adj_d[bc_i.edge_b[$clog2(NumV)-1:0]] = 1'b1;
        inc = inc + 2'd1;
      end
      if (bc_i.edge_b == Idx) begin
        adj_d[bc_i.edge_a[$clog2(NumV)-1:0]] = 1'b1;
        inc = inc + 2'd1;
      end
      dsum = {1'b0, deg_q} + {{(DegW-1){1'b0}}, inc};
      deg_d = dsum[DegW] ? {DegW{1'b1}} : dsum[DegW-1:0];
    end else if (bc_i.color_en) begin
      if (bc_i.color_v == Idx) begin
        done_d = 1'b1;
      end else if (!done_q && adj_q[bc_i.color_v[$clog2(NumV)-1:0]] &&
                   !seen_q[bc_i.color_c]) begin
        seen_d[bc_i.color_c] = 1'b1;
        if (sat_q != {SatW{1'b1}}) sat_d = sat_q + 1'b1;
      end
    end
  end

  // strict compare keeps the lower index on ties
  assign cand = live_i && !done_q;
  always_comb begin
    better = !key_i.valid || sat_q > key_i.sat ||
             (sat_q == key_i.sat && deg_q > key_i.deg);
    key_d = key_i;
    if (cand && better) begin
      key_d.valid = 1'b1; key_d.sat = sat_q; key_d.deg = deg_q; key_d.idx = Idx;
    end
  end

  // key registered: the search moves one cell per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      adj_q <= '0; deg_q <= '0; seen_q <= '0; sat_q <= '0; done_q <= 1'b0;
      key_q <= '0;
    end else begin
      adj_q <= adj_d; deg_q <= deg_d; seen_q <= seen_d; sat_q <= sat_d;
      done_q <= done_d;
      key_q <= key_d;
    end
  end

  assign key_o  = key_q;
  assign seen_o = seen_q;
endmodule

// ----- rtl/dsatur_graph_coloring.sv -----
// dsatur graph colorer top level: controller, chain of vertex cells, output register
//
// usage: input beats carry cmd, first_vertex and second_vertex. cmd add-edge
// loads one undirected edge per cycle (one beat per clock, no stall) and
// produces nothing. cmd run starts a coloring: input stalls until the run is
// over. for each vertex the max search ripples through the registered cell
// chain (one cell per cycle) and the pick is registered, then the color step
// assigns its color and updates the neighbors. results (vertex, color,
// colors_used, last) leave through an output register; when the receiver
// stalls the controller waits.
// the color search is a 64-bit priority encode of the picked cell's seen set.
// after the last result the cells are cleared.
// reset (rst_ni low, asynchronous) empties the graph, sets vertex_count to 64.
// vertex_count is written through cfg_we_i / cfg_data_i; the user must write it
// only while idle, the block itself does not enforce this.
module dsatur_graph_coloring
  import dsat_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = MaxVertices
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [VcntW-1:0] cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             cmd_i,
  input  logic [VidW-1:0]  first_vertex_i,
  input  logic [VidW-1:0]  second_vertex_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [VidW-1:0]  vertex_o,
  output logic [VidW-1:0]  color_o,
  output logic [VcntW-1:0] colors_used_o,
  output logic             last_o
);
  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_PICK  = 4'b0010,
    S_COLOR = 4'b0100,
    S_CLEAR = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic [VcntW-1:0] vcnt_q;
  logic [VcntW-1:0] live_n;
  logic [VcntW-1:0] step_q, step_d;
  logic [VcntW-1:0] wait_q, wait_d;
  logic [VcntW-1:0] maxc_q, maxc_d;
  logic [VidW-1:0]  pick_q, pick_d;
  logic [63:0]      pick_seen_q, pick_seen_d;
  logic             ovalid_q, ovalid_d;
  logic [VidW-1:0]  ovtx_q, ovtx_d, ocol_q, ocol_d;
  logic [VcntW-1:0] oused_q, oused_d;
  logic             olast_q, olast_d;
  dsat_bcast_t      bc;
  dsat_key_t        key [MAX_VERTICES+1];
  logic [63:0]      seen [MAX_VERTICES];
  logic             acc;
  logic [VidW-1:0]  free_c;
  logic [VcntW-1:0] cplus;

  assign live_n = (vcnt_q > VcntW'(MAX_VERTICES)) ? VcntW'(MAX_VERTICES) : vcnt_q;
  assign in_stall_o = (state_q != S_IDLE);
  assign acc = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vcnt_q <= VcntW'(MaxVertices);
    else if (cfg_we_i) vcnt_q <= cfg_data_i;
  end

  // the cell chain: each cell folds itself into the running best key
  assign key[0] = '0;
  for (genvar g = 0; g < MAX_VERTICES; g++) begin : g_cell
    dsat_cell #(.NumV(MAX_VERTICES), .Idx(VidW'(g))) u_cell (
      .clk_i, .rst_ni, .bc_i(bc),
      .live_i(VcntW'(g) < live_n),
      .key_i(key[g]), .key_o(key[g+1]),
      .seen_o(seen[g])
    );
  end

  // smallest color not seen, capped at 63
  always_comb begin
    free_c = 6'd63;
    for (int i = 62; i >= 0; i--) begin
      if (!pick_seen_q[i]) free_c = VidW'(i);
    end
  end
  assign cplus = {1'b0, free_c} + 1'b1;

  always_comb begin
    state_d = state_q; step_d = step_q; maxc_d = maxc_q; pick_d = pick_q;
    wait_d = wait_q;
    pick_seen_d = pick_seen_q;
    ovalid_d = ovalid_q; ovtx_d = ovtx_q; ocol_d = ocol_q; oused_d = oused_q;
    olast_d = olast_q;
    bc = '0;
    if (ovalid_q && !out_stall_i) ovalid_d = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (acc && cmd_i == CmdAddEdge) begin
          bc.edge_en = {1'b0, first_vertex_i} < live_n &&
                       {1'b0, second_vertex_i} < live_n;
          bc.edge_a = first_vertex_i;
          bc.edge_b = second_vertex_i;
        end else if (acc && cmd_i == CmdRun) begin
          step_d = '0;
          wait_d = '0;
          maxc_d = 7'd1;
          state_d = (live_n == '0) ? S_CLEAR : S_PICK;
        end
      end
      S_PICK: begin
        // the chain end is valid once every cell has seen the new state
        if (wait_q == VcntW'(MAX_VERTICES)) begin
          pick_d = key[MAX_VERTICES].idx;
          pick_seen_d = seen[key[MAX_VERTICES].idx];
          state_d = S_COLOR;
        end else begin
          wait_d = wait_q + 1'b1;
        end
      end
      S_COLOR: begin
        if (!ovalid_d) begin
          bc.color_en = 1'b1;
          bc.color_v = pick_q;
          bc.color_c = free_c;
          if (cplus > maxc_q) maxc_d = cplus;
          ovalid_d = 1'b1;
          ovtx_d = pick_q;
          ocol_d = free_c;
          oused_d = (cplus > maxc_q) ? cplus : maxc_q;
          olast_d = (step_q + 1'b1 == live_n);
          step_d = step_q + 1'b1;
          wait_d = '0;
          state_d = (step_q + 1'b1 == live_n) ? S_CLEAR : S_PICK;
        end
      end
      S_CLEAR: begin
        bc.clear = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; step_q <= '0; maxc_q <= 7'd1; ovalid_q <= 1'b0;
      wait_q <= '0;
    end else begin
      state_q <= state_d; step_q <= step_d; maxc_q <= maxc_d; ovalid_q <= ovalid_d;
      wait_q <= wait_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pick_q <= pick_d; pick_seen_q <= pick_seen_d;
    ovtx_q <= ovtx_d; ocol_q <= ocol_d; oused_q <= oused_d; olast_q <= olast_d;
  end

  assign out_valid_o   = ovalid_q;
  assign vertex_o      = ovtx_q;
  assign color_o       = ocol_q;
  assign colors_used_o = oused_q;
  assign last_o        = olast_q;
endmodule

// ----- rtl/dsat_checker.sv -----
// port-level checks for the dsatur colorer
module dsat_checker
  import dsat_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_stall_o,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic [VidW-1:0]  vertex_o,
  input logic [VidW-1:0]  color_o,
  input logic [VcntW-1:0] colors_used_o,
  input logic             last_o
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(vertex_o) && $stable(last_o))
    else $error("stalled result changed");
  a_color_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> {1'b0, color_o} < colors_used_o)
    else $error("color beyond colors_used");
  a_busy_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_o |=> in_stall_o)
    else $error("input accepted mid run");
endmodule

bind dsatur_graph_coloring dsat_checker u_dsat_checker (
  .clk_i, .rst_ni, .in_stall_o, .out_valid_o, .out_stall_i,
  .vertex_o, .color_o, .colors_used_o, .last_o
);

// ----- tb/tb_top.sv -----
// self-checking testbench for the dsatur graph colorer
module tb_top;
  import dsat_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned SettleCycles = 12;
  localparam int unsigned HoldCycles = 300;

  // what a directed row does
  typedef enum logic [1:0] {
    RowCfg,
    RowEdge,
    RowRun
  } row_kind_e;

  // one colored vertex as it leaves the block
  typedef struct packed {
    logic [VidW-1:0]  vertex;
    logic [VidW-1:0]  color;
    logic [VcntW-1:0] colors_used;
    logic             last;
  } coloring_t;

  typedef struct packed {
    row_kind_e        kind;
    logic [VcntW-1:0] a;
    logic [VidW-1:0]  b;
    logic             typed;
    coloring_t        typed_res;
  } row_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic [VcntW-1:0] cfg_data_i = '0;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  logic             cmd_i = CmdAddEdge;
  logic [VidW-1:0]  first_vertex_i = '0;
  logic [VidW-1:0]  second_vertex_i = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic [VidW-1:0]  vertex_o;
  logic [VidW-1:0]  color_o;
  logic [VcntW-1:0] colors_used_o;
  logic             last_o;

  dsatur_graph_coloring uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .cmd_i          (cmd_i),
    .first_vertex_i (first_vertex_i),
    .second_vertex_i(second_vertex_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .vertex_o       (vertex_o),
    .color_o        (color_o),
    .colors_used_o  (colors_used_o),
    .last_o         (last_o)
  );

  // shadow copy of the graph and coloring state
  bit [63:0]       adj_mask [64];
  bit [DegW-1:0]   deg_cnt [64];
  bit [63:0]       seen_colors [64];
  bit [SatW-1:0]   sat_cnt [64];
  bit [63:0]       colored_set;
  bit [VcntW-1:0]  palette_size;
  bit [VcntW-1:0]  vertex_count;

  coloring_t pending_colorings[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned send_idle_pct = 11;
  int unsigned recv_idle_pct = 49;
  bit hold_req = 1'b0;

  // clock and cycle budget
  initial begin
    forever begin
      #5 clk_i = ~clk_i;
      if (clk_i) begin
        cycles++;
        if (cycles > CycleLimit) begin
          $display("FAIL dsatur_graph_coloring");
          $finish;
        end
      end
    end
  end

  task automatic clear_graph();
    for (int i = 0; i < 64; i++) begin
      adj_mask[i] = '0;
      deg_cnt[i] = '0;
      seen_colors[i] = '0;
      sat_cnt[i] = '0;
    end
    colored_set = '0;
    palette_size = 1;
  endtask

  function automatic int unsigned live_vertices();
    return (vertex_count > MaxVertices) ? MaxVertices : vertex_count;
  endfunction

  // edge load: both ends must be live, degree saturates
  task automatic load_edge(input int unsigned a, input int unsigned b);
    if (a < live_vertices() && b < live_vertices()) begin
      adj_mask[a][b] = 1'b1;
      adj_mask[b][a] = 1'b1;
      if (deg_cnt[a] != 8'hff) deg_cnt[a]++;
      if (deg_cnt[b] != 8'hff) deg_cnt[b]++;
    end
  endtask

  // full dsatur pass over the shadow graph, one coloring per vertex
  task automatic color_graph(ref coloring_t order[$]);
    int pick;
    int unsigned c;
    int unsigned n;
    coloring_t r;
    n = live_vertices();
    for (int unsigned step = 0; step < n; step++) begin
      pick = -1;
      for (int v = 0; v < n; v++) begin
        if (colored_set[v]) continue;
        if (pick < 0 || sat_cnt[v] > sat_cnt[pick] ||
            (sat_cnt[v] == sat_cnt[pick] && deg_cnt[v] > deg_cnt[pick]))
          pick = v;
      end
      if (pick < 0) break;
      c = 0;
      while (c < 63 && seen_colors[pick][c]) c++;
      if (c + 1 > palette_size) palette_size = VcntW'(c + 1);
      colored_set[pick] = 1'b1;
      // neighbors pick up the new color once; self loop is already colored
      for (int u = 0; u < n; u++) begin
        if (!adj_mask[pick][u] || colored_set[u] || seen_colors[u][c]) continue;
        seen_colors[u][c] = 1'b1;
        if (sat_cnt[u] != 7'h7f) sat_cnt[u]++;
      end
      r.vertex = VidW'(pick);
      r.color = VidW'(c);
      r.colors_used = palette_size;
      r.last = (step + 1 == n);
      order = {order, r};
    end
    clear_graph();
  endtask

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    mismatches++;
  endtask

  // present one beat and hold it until the block takes it
  task automatic send_beat(input logic cmd, input int unsigned a, input int unsigned b,
                           input bit typed, input coloring_t typed_res);
    coloring_t order[$];
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i <= cmd;
    first_vertex_i <= VidW'(a);
    second_vertex_i <= VidW'(b);
    do @(posedge clk_i); while (in_stall_o);
    if (cmd == CmdAddEdge) begin
      load_edge(a, b);
    end else begin
      color_graph(order);
      // a typed row stands in for a one-vertex run
      if (typed) order = '{typed_res};
      foreach (order[i]) pending_colorings = {pending_colorings, order[i]};
    end
  endtask

  // lower valid, let every result out, then give the clear pass time
  task automatic go_idle();
    in_valid_i <= 1'b0;
    while (pending_colorings.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_count(input int unsigned value);
    go_idle();
    cfg_we_i <= 1'b1;
    cfg_data_i <= VcntW'(value);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    vertex_count = VcntW'(value);
  endtask

  // receiver: random stalls plus one long hold-off on request
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // result checker: every accepted beat against the oldest expectation
  initial begin
    coloring_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (pending_colorings.size() == 0) begin
          report("unexpected beat vertex", vertex_o, -1);
        end else begin
          want = pending_colorings.pop_front();
          if (vertex_o !== want.vertex) report("vertex", vertex_o, want.vertex);
          if (color_o !== want.color) report("color", color_o, want.color);
          if (colors_used_o !== want.colors_used)
            report("colors_used", colors_used_o, want.colors_used);
          if (last_o !== want.last) report("last", last_o, want.last);
        end
      end
    end
  end

  // directed rows: tiny graphs, range edges, count extremes, self loops
  row_t directed[] = '{
    '{RowCfg, 7'd1, 6'd0, 1'b0, '0},
    '{RowEdge, 7'd0, 6'd0, 1'b0, '0},
    '{RowEdge, 7'd1, 6'd0, 1'b0, '0},
    '{RowEdge, 7'd63, 6'd63, 1'b0, '0},
    '{RowRun, 7'd0, 6'd0, 1'b1, '{6'd0, 6'd0, 7'd1, 1'b1}},
    '{RowCfg, 7'd0, 6'd0, 1'b0, '0},
    '{RowEdge, 7'd0, 6'd0, 1'b0, '0},
    '{RowRun, 7'd0, 6'd0, 1'b0, '0},
    '{RowCfg, 7'd127, 6'd0, 1'b0, '0},
    '{RowEdge, 7'd0, 6'd63, 1'b0, '0},
    '{RowEdge, 7'd63, 6'd0, 1'b0, '0},
    '{RowEdge, 7'd63, 6'd63, 1'b0, '0},
    '{RowEdge, 7'd21, 6'd42, 1'b0, '0},
    '{RowEdge, 7'd42, 6'd0, 1'b0, '0},
    '{RowEdge, 7'd42, 6'd21, 1'b0, '0},
    '{RowRun, 7'd0, 6'd0, 1'b0, '0},
    '{RowCfg, 7'd3, 6'd0, 1'b0, '0},
    '{RowEdge, 7'd0, 6'd1, 1'b0, '0},
    '{RowEdge, 7'd1, 6'd2, 1'b0, '0},
    '{RowEdge, 7'd2, 6'd0, 1'b0, '0},
    '{RowRun, 7'd0, 6'd0, 1'b0, '0},
    '{RowCfg, 7'd64, 6'd0, 1'b0, '0},
    '{RowRun, 7'd0, 6'd0, 1'b0, '0}
  };

  // counts per random phase; 127 exercises the clamp, 1 the smallest graph
  int unsigned phase_counts[] = '{64, 2, 17, 127, 40, 5, 64, 33, 1, 64};

  initial begin
    int unsigned n;
    int unsigned edges;
    vertex_count = 64;
    clear_graph();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) begin
      case (directed[i].kind)
        RowCfg: write_count(directed[i].a);
        RowEdge: send_beat(CmdAddEdge, directed[i].a, directed[i].b, 1'b0, '0);
        default: send_beat(CmdRun, 0, 0, directed[i].typed, directed[i].typed_res);
      endcase
    end

    foreach (phase_counts[p]) begin
      // idle pattern moves through three regimes over the phases
      if (p == 4) begin
        send_idle_pct = 49;
        recv_idle_pct = 11;
      end else if (p == 7) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_count(phase_counts[p]);
      n = live_vertices();
      edges = $urandom_range(14, 10);
      for (int k = 0; k < edges; k++) begin
        if ($urandom_range(99) < 85)
          send_beat(CmdAddEdge, $urandom_range(n - 1), $urandom_range(n - 1), 1'b0, '0);
        else
          send_beat(CmdAddEdge, $urandom_range(63), $urandom_range(63), 1'b0, '0);
      end
      // long receiver hold-off while the run and further edges keep coming
      if (p == 2) hold_req = 1'b1;
      send_beat(CmdRun, $urandom_range(63), $urandom_range(63), 1'b0, '0);
      if (p == 2) begin
        for (int k = 0; k < 3; k++)
          send_beat(CmdAddEdge, $urandom_range(n - 1), $urandom_range(n - 1), 1'b0, '0);
      end
    end

    go_idle();
    if (mismatches == 0) begin
      $display("PASS dsatur_graph_coloring");
    end else begin
      $display("FAIL dsatur_graph_coloring");
    end
    $finish;
  end
endmodule
